// ----- rtl/core/sll_pkg.sv -----
package sll_pkg;
    localparam int POOL_NODES  = 32;
    localparam int VALUE_BITS  = 32;
    localparam int IDX_BITS    = $clog2(POOL_NODES + 1);
    localparam int ADDR_BITS   = $clog2(POOL_NODES);
    localparam int MAX_RESULTS = 32;

    localparam logic [IDX_BITS-1:0] NIL = IDX_BITS'(POOL_NODES);

    typedef enum logic [3:0] {
        M_CREATE    = 4'd0,
        M_DUMP      = 4'd1,
        M_ADD_FRONT = 4'd2,
        M_ADD_END   = 4'd3,
        M_ADD_AFTER = 4'd4,
        M_ADD_BEFORE= 4'd5,
        M_DEL_FRONT = 4'd6,
        M_DEL_END   = 4'd7,
        M_DEL_MATCH = 4'd8,
        M_DEL_AFTER = 4'd9,
        M_DEL_BEFORE= 4'd10,
        M_CLEAR     = 4'd11
    } t_mode;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [3:0]  mode;
        logic [31:0] match_value;
        logic [31:0] data_value;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic        item_valid;
        logic [31:0] item_value;
        logic [5:0]  list_length;
        logic        last;
    } t_rsp;
endpackage

// ----- rtl/core/sll_if.sv -----
interface sll_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/core/singly_linked_list_engine_core.sv -----
// singly linked list engine over a fixed pool of nodes
// i_cmd carries one command beat: mode, match_value, data_value.
// o_rsp returns result beats: status, item_valid, item_value, list_length,
// last. every command gives one beat, except a dump of a non-empty list,
// which gives one beat per list element in order (last set on the final one).
// the node values and links sit in two synchronous memories with a
// registered read; the walk visits one node at a time, issuing its read
// in S_WAIT and evaluating it in S_EVAL, and a search or tail walk is
// bounded by the pool size.
// a dump delivers its beats one node at a time while the receiver takes them.
// a new command is taken only when the previous one is fully answered.
// reset empties the list and frees every node; the memories are not
// cleared, since only nodes on the list are ever read.
// when the receiver stalls, the result beat holds in the output register
// and the engine waits; nothing is dropped.
module singly_linked_list_engine_core
    import sll_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    sll_if.sink   i_cmd,
    sll_if.source o_rsp
);
    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_WAIT, S_EVAL, S_ALLOC, S_DROP, S_OUT
    } t_state;

    logic [VALUE_BITS-1:0] mem_val [POOL_NODES];
    logic [IDX_BITS-1:0]   mem_lnk [POOL_NODES];

    t_state r_state;
    logic [3:0] r_mode;
    logic [VALUE_BITS-1:0] r_mv, r_dv;
    logic [POOL_NODES-1:0] r_free;
    logic [IDX_BITS-1:0]   r_head, r_cur, r_prev, r_pprev;
    logic [5:0]            r_count, r_steps;
    logic [VALUE_BITS-1:0] r_rd_val;
    logic [IDX_BITS-1:0]   r_rd_lnk;
    logic                  r_out_valid;
    t_rsp                  r_rsp;
    logic                  r_dump_done;

    // memory port
    logic                  wr_en;
    logic [ADDR_BITS-1:0]  wr_addr, rd_addr;
    logic [VALUE_BITS-1:0] wr_val;
    logic [IDX_BITS-1:0]   wr_lnk;
    logic                  wr_val_en;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_lnk[wr_addr] <= wr_lnk;
            if (wr_val_en) begin
                mem_val[wr_addr] <= wr_val;
            end
        end
        r_rd_val <= mem_val[rd_addr];
        r_rd_lnk <= mem_lnk[rd_addr];
    end

    // lowest free node
    logic [IDX_BITS-1:0] free_idx;
    always_comb begin
        free_idx = NIL;
        for (int i = POOL_NODES - 1; i >= 0; i--) begin
            if (r_free[i]) begin
                free_idx = IDX_BITS'(i);
            end
        end
    end

    function automatic logic [VALUE_BITS-1:0] to_store(input logic [31:0] raw);
        logic [63:0] ext;
        ext = {{32{raw[31]}}, raw};
        return ext[VALUE_BITS-1:0];
    endfunction

    function automatic logic [31:0] to_out(input logic [VALUE_BITS-1:0] v);
        logic [63:0] ext;
        ext = {{(64-VALUE_BITS){v[VALUE_BITS-1]}}, v};
        return ext[31:0];
    endfunction

    logic empty, full, is_search, is_tail, hit, at_end;
    assign empty     = (r_head == NIL);
    assign full      = (r_free == '0);
    assign is_search = (r_mode == M_ADD_AFTER) || (r_mode == M_ADD_BEFORE)
                    || (r_mode == M_DEL_MATCH) || (r_mode == M_DEL_AFTER)
                    || (r_mode == M_DEL_BEFORE);
    assign is_tail   = (r_mode == M_ADD_END) || (r_mode == M_DEL_END);
    assign hit       = (r_rd_val == r_mv);
    assign at_end    = (r_rd_lnk == NIL);

    assign i_cmd.ready   = (r_state == S_IDLE) && !r_out_valid;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_rsp;

    // node to patch at drop, and link value written at alloc or drop
    logic [IDX_BITS-1:0] r_new;
    logic [IDX_BITS-1:0] r_link_tgt;

    always_comb begin
        wr_en     = 1'b0;
        wr_val_en = 1'b0;
        wr_addr   = r_cur[ADDR_BITS-1:0];
        wr_val    = r_dv;
        wr_lnk    = NIL;
        rd_addr   = r_cur[ADDR_BITS-1:0];
        if (r_state == S_ALLOC) begin
            wr_en     = 1'b1;
            wr_val_en = 1'b1;
            wr_addr   = free_idx[ADDR_BITS-1:0];
            wr_lnk    = r_link_tgt;
        end else if (r_state == S_DROP && r_new != NIL) begin
            // relink step: r_new holds the node to patch
            wr_en   = 1'b1;
            wr_addr = r_new[ADDR_BITS-1:0];
            wr_lnk  = r_link_tgt;
        end
    end

    // result status, set at read or eval
    logic [1:0] r_status;

    // a result beat enters the output register this cycle
    logic rsp_load;
    assign rsp_load = ((r_state == S_EVAL) && (r_mode == M_DUMP))
                   || ((r_state == S_OUT) && !((r_mode == M_DUMP) && (r_status == ST_OK))
                       && (!r_out_valid || o_rsp.ready));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free      <= '1;
            r_head      <= NIL;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (rsp_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid && i_cmd.ready) begin
                        r_mode   <= i_cmd.payload.mode;
                        r_mv     <= to_store(i_cmd.payload.match_value);
                        r_dv     <= to_store(i_cmd.payload.data_value);
                        r_cur    <= r_head;
                        r_prev   <= NIL;
                        r_pprev  <= NIL;
                        r_steps  <= '0;
                        r_new    <= NIL;
                        r_status <= ST_OK;
                        r_dump_done <= 1'b0;
                        r_state  <= S_READ;
                    end
                end
                S_READ: begin
                    // decide whether a walk is needed
                    case (r_mode)
                        M_CREATE: begin
                            r_free     <= '1;
                            r_head     <= NIL;
                            r_count    <= '0;
                            r_link_tgt <= NIL;
                            r_state    <= S_ALLOC;
                        end
                        M_CLEAR: begin
                            r_free  <= '1;
                            r_head  <= NIL;
                            r_count <= '0;
                            r_state <= S_OUT;
                        end
                        M_DUMP: begin
                            if (empty) begin
                                r_status <= ST_EMPTY;
                                r_state  <= S_OUT;
                            end else r_state <= S_WAIT;
                        end
                        M_ADD_FRONT: begin
                            if (full) begin
                                r_status <= ST_FULL;
                                r_state  <= S_OUT;
                            end else begin
                                r_link_tgt <= r_head;
                                r_state    <= S_ALLOC;
                            end
                        end
                        M_ADD_END: begin
                            if (full) begin
                                r_status <= ST_FULL;
                                r_state  <= S_OUT;
                            end else if (empty) begin
                                r_link_tgt <= NIL;
                                r_state    <= S_ALLOC;
                            end else r_state <= S_WAIT;
                        end
                        M_ADD_AFTER, M_ADD_BEFORE: begin
                            if (full) begin
                                r_status <= ST_FULL;
                                r_state  <= S_OUT;
                            end else if (empty) begin
                                r_status <= ST_EMPTY;
                                r_state  <= S_OUT;
                            end else r_state <= S_WAIT;
                        end
                        M_DEL_FRONT, M_DEL_END, M_DEL_MATCH, M_DEL_AFTER,
                        M_DEL_BEFORE: begin
                            if (empty) begin
                                r_status <= ST_EMPTY;
                                r_state  <= S_OUT;
                            end else r_state <= S_WAIT;
                        end
                        default: r_state <= S_OUT;
                    endcase
                end
                S_WAIT: begin
                    // read of r_cur issued this cycle
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (r_mode == M_DUMP) begin
                        r_rsp.status      <= ST_OK;
                        r_rsp.item_valid  <= 1'b1;
                        r_rsp.item_value  <= to_out(r_rd_val);
                        r_rsp.list_length <= r_count;
                        r_rsp.last        <= at_end || (r_steps == 6'(MAX_RESULTS - 1));
                        r_dump_done       <= at_end || (r_steps == 6'(MAX_RESULTS - 1));
                        r_cur             <= r_rd_lnk;
                        r_steps           <= r_steps + 6'd1;
                        r_state           <= S_OUT;
                    end else if (r_mode == M_DEL_FRONT) begin
                        r_free[r_cur[ADDR_BITS-1:0]] <= 1'b1;
                        r_count <= r_count - 6'd1;
                        if (r_new == NIL) begin
                            r_head  <= r_rd_lnk;
                            r_state <= S_OUT;
                        end else begin
                            // delete-after second phase: match skips the follower
                            r_link_tgt <= r_rd_lnk;
                            r_state    <= S_DROP;
                        end
                    end else if (is_tail) begin
                        if (at_end || r_steps == 6'(POOL_NODES - 1)) begin
                            if (r_mode == M_ADD_END) begin
                                r_new      <= r_cur;
                                r_link_tgt <= NIL;
                                r_state    <= S_ALLOC;
                            end else begin
                                r_free[r_cur[ADDR_BITS-1:0]] <= 1'b1;
                                r_count <= r_count - 6'd1;
                                if (r_prev == NIL) begin
                                    r_head  <= NIL;
                                    r_state <= S_OUT;
                                end else begin
                                    r_new      <= r_prev;
                                    r_link_tgt <= NIL;
                                    r_state    <= S_DROP;
                                end
                            end
                        end else begin
                            r_prev  <= r_cur;
                            r_cur   <= r_rd_lnk;
                            r_steps <= r_steps + 6'd1;
                            r_state <= S_WAIT;
                        end
                    end else if (is_search) begin
                        if (hit) begin
                            case (r_mode)
                                M_ADD_AFTER: begin
                                    r_new      <= r_cur;
                                    r_link_tgt <= r_rd_lnk;
                                    r_state    <= S_ALLOC;
                                end
                                M_ADD_BEFORE: begin
                                    r_new      <= r_prev;
                                    r_link_tgt <= r_cur;
                                    r_state    <= S_ALLOC;
                                end
                                M_DEL_MATCH: begin
                                    r_free[r_cur[ADDR_BITS-1:0]] <= 1'b1;
                                    r_count <= r_count - 6'd1;
                                    if (r_prev == NIL) begin
                                        r_head  <= r_rd_lnk;
                                        r_state <= S_OUT;
                                    end else begin
                                        r_new      <= r_prev;
                                        r_link_tgt <= r_rd_lnk;
                                        r_state    <= S_DROP;
                                    end
                                end
                                M_DEL_AFTER: begin
                                    if (at_end) begin
                                        r_status <= ST_NOTFOUND;
                                        r_state  <= S_OUT;
                                    end else begin
                                        // fetch the follower's link first
                                        r_new   <= r_cur;
                                        r_cur   <= r_rd_lnk;
                                        r_mode  <= M_DEL_FRONT;
                                        r_state <= S_WAIT;
                                    end
                                end
                                default: begin
                                    if (r_prev == NIL) begin
                                        r_status <= ST_NOTFOUND;
                                        r_state  <= S_OUT;
                                    end else begin
                                        r_free[r_prev[ADDR_BITS-1:0]] <= 1'b1;
                                        r_count <= r_count - 6'd1;
                                        if (r_pprev == NIL) begin
                                            r_head  <= r_cur;
                                            r_state <= S_OUT;
                                        end else begin
                                            r_new      <= r_pprev;
                                            r_link_tgt <= r_cur;
                                            r_state    <= S_DROP;
                                        end
                                    end
                                end
                            endcase
                        end else if (at_end || r_steps == 6'(POOL_NODES - 1)) begin
                            r_status <= ST_NOTFOUND;
                            r_state  <= S_OUT;
                        end else begin
                            r_pprev <= r_prev;
                            r_prev  <= r_cur;
                            r_cur   <= r_rd_lnk;
                            r_steps <= r_steps + 6'd1;
                            r_state <= S_WAIT;
                        end
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_ALLOC: begin
                    r_free[free_idx[ADDR_BITS-1:0]] <= 1'b0;
                    r_count <= r_count + 6'd1;
                    if (r_new == NIL) begin
                        r_head  <= free_idx;
                        r_state <= S_OUT;
                    end else begin
                        r_link_tgt <= free_idx;
                        r_state    <= S_DROP;
                    end
                end
                S_DROP: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (r_mode == M_DUMP && !r_dump_done && r_status == ST_OK) begin
                        if (!r_out_valid || o_rsp.ready) begin
                            r_state <= S_WAIT;
                        end
                    end else if (r_mode == M_DUMP && r_status == ST_OK) begin
                        r_state <= S_IDLE;
                    end else if (!r_out_valid || o_rsp.ready) begin
                        r_rsp.status      <= r_status;
                        r_rsp.item_valid  <= 1'b0;
                        r_rsp.item_value  <= '0;
                        r_rsp.list_length <= r_count;
                        r_rsp.last        <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_cmd.ready)
        else $error("command taken while busy");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= 6'(POOL_NODES)))
        else $error("node count out of range");
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_head == NIL) |-> (r_count == '0))
        else $error("empty list with nonzero count");
endmodule
